// ----- hw/rtl/gwur_pkg.sv -----
`timescale 1ns / 1ps

package gwur_pkg;

	localparam int ANGLE_W  = 18;
	localparam int VEC_W    = 33;
	localparam int ZW       = 24;
	localparam int OUT_W    = 17;
	localparam int RND_W    = 20;

	localparam int NUM_ITERS      = 20;
	localparam int ITERS_PER_STG  = 2;
	localparam int NUM_STG        = NUM_ITERS / ITERS_PER_STG;
	localparam int ITER_IDX_W     = $clog2(NUM_ITERS);

	localparam logic signed [ANGLE_W-1:0] PI_Q13      = 18'sd25736;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 18'sd12868;
	localparam logic signed [30:0]        GAIN_Q30    = 31'sd652032874;
	localparam logic signed [RND_W-1:0]   OUT_MAX     = 20'sd46341;

	// atan(2^-i) in Q.20, rounded
	localparam logic signed [ZW-1:0] ATAN_Q20 [NUM_ITERS] = '{
		24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
		24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
		24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
		24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ZW-1:0]    z;
	} gwur_vec_t;

	function automatic gwur_vec_t cordic_iter(input gwur_vec_t v, input int unsigned i);
		gwur_vec_t               r;
		logic signed [VEC_W-1:0] xs;
		logic signed [VEC_W-1:0] ys;
		xs = v.x >>> i;
		ys = v.y >>> i;
		if (!v.z[ZW-1]) begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - ATAN_Q20[i[ITER_IDX_W-1:0]];
		end else begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + ATAN_Q20[i[ITER_IDX_W-1:0]];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/grid_wind_u_rotation.sv -----
`timescale 1ns / 1ps

// Rotates a grid wind vector (u, v in Q8.8) by a grid angle (Q3.13 radians, folded to
// a when a < pi/2, else pi - a, then +pi with u, v negated below -pi/2) and returns
// u*cos + v*sin as Q9.8, rounded half up and clamped to +-46341; a zero vector gives 0.
// Fully pipelined through one angle-fold stage, ten CORDIC stages of two iterations
// each, one gain-multiply stage and the round/clamp output register. One request per
// cycle unless backpressure has filled the pipeline; empty stages keep filling.
module grid_wind_u_rotation import gwur_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // wind_u[15:0], wind_v[31:16], grid_angle[47:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // rotated_u[16:0], zero fill [23:17]
);

	logic                    prep_vld;
	logic                    prep_rdy;
	gwur_vec_t               prep_vec;
	logic                    cor_vld;
	logic                    cor_rdy;
	gwur_vec_t               cor_vec;
	logic signed [OUT_W-1:0] rotated_u;

	gwur_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.wind_u     (s_axis_tdata[15:0]),
		.wind_v     (s_axis_tdata[31:16]),
		.grid_angle (s_axis_tdata[47:32]),
		.out_valid  (prep_vld),
		.out_ready  (prep_rdy),
		.out_vec    (prep_vec)
	);

	gwur_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_vld),
		.in_ready  (prep_rdy),
		.in_vec    (prep_vec),
		.out_valid (cor_vld),
		.out_ready (cor_rdy),
		.out_vec   (cor_vec)
	);

	gwur_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_vld),
		.in_ready  (cor_rdy),
		.in_vec    (cor_vec),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (rotated_u)
	);

	assign m_axis_tdata = {7'b0, rotated_u};

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (rotated_u <= OUT_W'(OUT_MAX)) && (rotated_u >= OUT_W'(-OUT_MAX)))
		else $error("rotated_u outside clamp range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while the output side moves");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cor_vld, 2) || $past(m_axis_tvalid, 2))
		else $error("result appeared without a request in flight");

endmodule

// ----- hw/rtl/gwur_prep.sv -----
`timescale 1ns / 1ps

module gwur_prep import gwur_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [15:0]      wind_u,
	input  logic [15:0]      wind_v,
	input  logic [15:0]      grid_angle,
	output logic             out_valid,
	input  logic             out_ready,
	output gwur_vec_t        out_vec
);

	logic signed [15:0]        a;
	logic signed [ANGLE_W-1:0] t_raw;
	logic signed [ANGLE_W-1:0] t_fold;
	logic                      neg;
	logic signed [16:0]        u_f;
	logic signed [16:0]        v_f;
	gwur_vec_t                 vec_d;
	logic                      vld_s1;
	gwur_vec_t                 vec_s1;

	always_comb begin
		a      = signed'(grid_angle);
		t_raw  = (ANGLE_W'(a) < HALF_PI_Q13) ? ANGLE_W'(a) : PI_Q13 - ANGLE_W'(a);
		neg    = t_raw < -HALF_PI_Q13;
		t_fold = neg ? t_raw + PI_Q13 : t_raw;
		u_f    = neg ? -(17'(signed'(wind_u))) : 17'(signed'(wind_u));
		v_f    = neg ? -(17'(signed'(wind_v))) : 17'(signed'(wind_v));
		vec_d.x = VEC_W'(u_f) <<< 14;
		vec_d.y = VEC_W'(v_f) <<< 14;
		vec_d.z = -(ZW'(t_fold) <<< 7);
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = vld_s1;
	assign out_vec   = vec_s1;

endmodule

// ----- hw/rtl/gwur_cordic.sv -----
`timescale 1ns / 1ps

module gwur_cordic import gwur_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  gwur_vec_t in_vec,
	output logic      out_valid,
	input  logic      out_ready,
	output gwur_vec_t out_vec
);

	logic      stg_vld_s [NUM_STG];
	gwur_vec_t stg_vec_s [NUM_STG];
	logic      stg_rdy   [NUM_STG];

	for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
		logic      prev_vld;
		gwur_vec_t prev_vec;
		gwur_vec_t mid_vec;
		gwur_vec_t nxt_vec;
		logic      down_rdy;

		if (s == 0) begin : g_first
			assign prev_vld = in_valid;
			assign prev_vec = in_vec;
		end else begin : g_mid
			assign prev_vld = stg_vld_s[s-1];
			assign prev_vec = stg_vec_s[s-1];
		end

		if (s == NUM_STG - 1) begin : g_last
			assign down_rdy = out_ready;
		end else begin : g_notlast
			assign down_rdy = stg_rdy[s+1];
		end

		assign mid_vec    = cordic_iter(prev_vec, s * ITERS_PER_STG);
		assign nxt_vec    = cordic_iter(mid_vec, s * ITERS_PER_STG + 1);
		assign stg_rdy[s] = !stg_vld_s[s] || down_rdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_vld_s[s] <= 1'b0;
			end else if (stg_rdy[s]) begin
				stg_vld_s[s] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[s] && prev_vld) begin
				stg_vec_s[s] <= nxt_vec;
			end
		end
	end

	assign in_ready  = stg_rdy[0];
	assign out_valid = stg_vld_s[NUM_STG-1];
	assign out_vec   = stg_vec_s[NUM_STG-1];

endmodule

// ----- hw/rtl/gwur_scale.sv -----
`timescale 1ns / 1ps

module gwur_scale import gwur_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  gwur_vec_t               in_vec,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] result
);

	logic                    vld_s1;
	logic signed [62:0]      prod_s1;
	logic                    vld_s2;
	logic signed [OUT_W-1:0] res_s2;
	logic                    rdy_s1;
	logic                    rdy_s2;
	logic signed [63:0]      rnd_sum;
	logic signed [RND_W-1:0] rnd;
	logic signed [OUT_W-1:0] sat;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// round the gain-corrected product half up to Q9.8 and clamp
	always_comb begin
		rnd_sum = 64'(prod_s1) + (64'sd1 <<< 43);
		rnd     = rnd_sum[63:44];
		if (rnd > OUT_MAX) begin
			sat = OUT_W'(OUT_MAX);
		end else if (rnd < -OUT_MAX) begin
			sat = OUT_W'(-OUT_MAX);
		end else begin
			sat = rnd[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			prod_s1 <= signed'(in_vec.x[31:0]) * GAIN_Q30;
		end
		if (rdy_s2 && vld_s1) begin
			res_s2 <= sat;
		end
	end

	assign out_valid = vld_s2;
	assign result    = res_s2;

	a_rise_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s2) |-> $past(vld_s1))
		else $error("result valid without a product in stage 1");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import gwur_pkg::*;

	localparam int   STALL_LIMIT = 2000;
	localparam int   HOLD_CYCLES = 300;
	localparam int   TAIL_CYCLES = 30;
	localparam int   ANG_PI      = 25736;
	localparam int   ANG_HALF_PI = 12868;
	localparam longint ATAN_STEP [20] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
	};

	class rotation_scoreboard;
		logic [OUT_W-1:0] expected_u_q[$];
		int               errors;

		function logic [OUT_W-1:0] rotated_u_of(logic signed [15:0] wu,
			logic signed [15:0] wv, logic signed [15:0] ang);
			longint u, v, t, x, y, z, xs, ys, prod, r;
			u = wu;
			v = wv;
			t = (longint'(ang) < ANG_HALF_PI) ? longint'(ang) : ANG_PI - longint'(ang);
			if (t < -ANG_HALF_PI) begin
				t = t + ANG_PI;
				u = -u;
				v = -v;
			end
			x = u * 16384;
			y = v * 16384;
			z = -t * 128;
			for (int i = 0; i < 20; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_STEP[i];
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_STEP[i];
				end
			end
			prod = x * 64'sd652032874;
			r = (prod + (64'sd1 <<< 43)) >>> 44;
			if (r > 46341)
				r = 46341;
			if (r < -46341)
				r = -46341;
			return r[OUT_W-1:0];
		endfunction

		function void note_request(logic [47:0] d);
			expected_u_q = {expected_u_q, rotated_u_of(d[15:0], d[31:16], d[47:32])};
		endfunction

		function void check_result(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (expected_u_q.size() == 0) begin
				$display("%0t: unexpected result rotated_u=%0d", $time, $signed(got));
				errors++;
			end else begin
				want = expected_u_q.pop_front();
				if (got !== want) begin
					$display("%0t: rotated_u mismatch: expected %0d, actual %0d",
						$time, $signed(want), $signed(got));
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_u_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	rotation_scoreboard sb;
	int tx_idle_pct;
	int rx_stall_pct;
	bit hold_off;

	grid_wind_u_rotation u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] pick_field(bit is_angle);
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(15)) - 16'd8;
			4: begin
				if (is_angle)
					return 16'(ANG_HALF_PI - 2 + $urandom_range(3));
				return 16'($urandom);
			end
			5: begin
				if (is_angle)
					return 16'(-ANG_HALF_PI - 2 + $urandom_range(3));
				return 16'($urandom);
			end
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_request(input logic [15:0] wu, input logic [15:0] wv,
		input logic [15:0] ang);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ang, wv, wu};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request({ang, wv, wu});
	endtask

	task automatic send_random(input int n);
		for (int k = 0; k < n; k++)
			send_request(pick_field(0), pick_field(0), pick_field(1));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls plus one long hold-off when requested
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[OUT_W-1:0]);
			if (hold_off && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		hold_off      = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector, extremes, angle folding edges, saturation corners
		send_request(16'sd0, 16'sd0, 16'sd0);
		send_request(16'sd0, 16'sd0, 16'h7fff);
		send_request(16'sd0, 16'sd0, 16'h8000);
		send_request(16'h7fff, 16'sd0, 16'sd0);
		send_request(16'h8000, 16'sd0, 16'sd0);
		send_request(16'sd0, 16'h7fff, 16'sd0);
		send_request(16'sd0, 16'h8000, 16'sd0);
		send_request(16'h8000, 16'h8000, 16'sd6434);
		send_request(16'h8000, 16'h8000, 16'sd19302);
		send_request(16'h8000, 16'h8000, -16'sd19302);
		send_request(16'h7fff, 16'h7fff, 16'sd6434);
		send_request(16'h7fff, 16'h8000, -16'sd6434);
		send_request(16'sd1000, -16'sd2000, 16'sd12867);
		send_request(16'sd1000, -16'sd2000, 16'sd12868);
		send_request(16'sd1000, -16'sd2000, 16'sd25736);
		send_request(16'sd1000, -16'sd2000, 16'h7fff);
		send_request(16'sd1000, -16'sd2000, -16'sd12868);
		send_request(16'sd1000, -16'sd2000, -16'sd12869);
		send_request(16'sd1000, -16'sd2000, 16'h8000);
		send_request(16'sd1, -16'sd1, 16'sd100);
		send_request(-16'sd1, 16'sd1, -16'sd100);
		drain();

		send_random(450);
		drain();
		tx_idle_pct = 64;
		send_random(450);
		drain();
		tx_idle_pct  = 0;
		rx_stall_pct = 64;
		send_random(450);
		drain();
		tx_idle_pct  = 14;
		rx_stall_pct = 14;
		send_random(450);
		drain();

		// long receiver hold-off while requests keep coming
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_off     = 1'b1;
		send_random(130);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/gwur_pkg.sv
hw/rtl/gwur_prep.sv
hw/rtl/gwur_cordic.sv
hw/rtl/gwur_scale.sv
hw/rtl/grid_wind_u_rotation.sv
bench/testbench.sv
